// ===== design/p24p_pkg.sv =====
// Package for the 24-bit PCM TDM output packer.
// Holds the fixed formats, configuration register codes and the PCM conversion.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package p24p_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int SAMPLE_FRAC = 23;
    localparam int GAIN_W      = 24;
    localparam int GAIN_FRAC   = 22;
    localparam int ACC_EXTRA   = 16;
    localparam int ACC_W       = GAIN_W + ACC_EXTRA;
    localparam int INC_W       = ACC_W + 1;
    localparam int PCM_W       = 24;
    localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
    localparam int CONV_W      = 40;
    localparam int LANES       = 4;
    localparam int SLOTS       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 24;
    localparam int FC_W        = 13;

    localparam logic [GAIN_W-1:0] UNITY_GAIN  = GAIN_W'(1) << GAIN_FRAC;
    localparam logic [GAIN_W-1:0] RST_GAIN    = 24'd4194304;
    localparam logic [FC_W-1:0]   RST_FRAMES  = 13'd64;

    localparam logic signed [CONV_W-1:0] PCM_POS_MAX = 40'sd8388607;
    localparam logic signed [CONV_W-1:0] PCM_NEG_MIN = -40'sd8388608;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_START = 2'd0,
        CFG_GAIN_END   = 2'd1,
        CFG_FRAMES     = 2'd2,
        CFG_MODE       = 2'd3
    } t_cfg_index;

    typedef enum logic {
        MODE_CLAMP_SCALE = 1'b0,
        MODE_SATURATE    = 1'b1
    } t_conv_mode;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic              busy;
        logic              last;
        t_conv_mode        mode;
        logic [GAIN_W-1:0] gain;
    } t_frame_ctl;

    // Clamp-and-scale by 8388607 reduces to a step of one toward zero.
    function automatic logic [PCM_W-1:0] to_pcm24(input logic signed [CONV_W-1:0] v,
                                                  input t_conv_mode mode);
        logic [PCM_W-1:0] r;
        r = '0;
        unique case (mode)
            MODE_CLAMP_SCALE: begin
                if (v >= PCM_POS_MAX) begin
                    r = PCM_W'(PCM_POS_MAX - 40'sd1);
                end else if (v <= PCM_NEG_MIN) begin
                    r = PCM_W'(PCM_NEG_MIN + 40'sd1);
                end else if (v > 40'sd0) begin
                    r = PCM_W'(v - 40'sd1);
                end else if (v < 40'sd0) begin
                    r = PCM_W'(v + 40'sd1);
                end else begin
                    r = '0;
                end
            end
            MODE_SATURATE: begin
                if (v > PCM_POS_MAX) begin
                    r = PCM_W'(PCM_POS_MAX);
                end else if (v < PCM_NEG_MIN) begin
                    r = PCM_W'(PCM_NEG_MIN);
                end else begin
                    r = PCM_W'(v);
                end
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/pcm24_tdm_output_packer.sv =====
// 24-bit PCM TDM output packer: top level with four sample lanes and the slot merge.
// Depends on p24p_pkg, p24p_ramp and p24p_lane.
//
// Takes one frame of four Q8.23 samples per cycle unless stalled by back-pressure
// or a ramp recompute, and returns six 24-bit PCM slots (main, cue, main) through
// the multiply and conversion registers, with tlast marking the last frame of a
// cue gain ramp block. Each cue sample is scaled by the ramping gain in its own
// multiplier lane. A write to the gain start, gain end or frame count register
// recomputes the ramp step in a bit-serial divider, one quotient bit per cycle,
// with s_axis_tready low meanwhile. The mode register takes effect at once.
`timescale 1ns / 1ps
`default_nettype none

module pcm24_tdm_output_packer #(
    parameter int MAX_FRAMES = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // main_left, main_right, cue_left, cue_right (32 bits each)
    input  wire logic [4*p24p_pkg::SAMPLE_W-1:0]  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // slot_main_left_a, slot_main_right_a, slot_cue_left, slot_cue_right,
    // slot_main_left_b, slot_main_right_b (24 bits each)
    output logic [6*p24p_pkg::PCM_W-1:0]          m_axis_tdata,
    output logic                                  m_axis_tlast,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [p24p_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [p24p_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import p24p_pkg::*;

    t_frame_ctl       ctl;
    logic             accept;
    logic             adv;
    logic             r_v1, r_v2;
    logic             r_last1, r_last2;
    logic [PCM_W-1:0] pcm [LANES];

    assign adv           = !r_v2 || m_axis_tready;
    assign s_axis_tready = (!r_v1 || adv) && !ctl.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    p24p_ramp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_ramp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .o_ctl       (ctl)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [GAIN_W-1:0] lane_gain;
        if (g < 2) begin : g_main
            assign lane_gain = UNITY_GAIN;
        end else begin : g_cue
            assign lane_gain = ctl.gain;
        end
        p24p_lane u_lane (
            .i_clk    (i_clk),
            .i_load   (accept),
            .i_adv    (r_v1 && adv),
            .i_sample (s_axis_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .i_gain   (lane_gain),
            .i_mode   (ctl.mode),
            .o_pcm    (pcm[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (adv) begin
                r_v1 <= 1'b0;
            end
            if (adv) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last1 <= ctl.last;
        end
        if (r_v1 && adv) begin
            r_last2 <= r_last1;
        end
    end

    assign m_axis_tvalid = r_v2;
    assign m_axis_tlast  = r_last2;
    assign m_axis_tdata  = {pcm[1], pcm[0], pcm[3], pcm[2], pcm[1], pcm[0]};

endmodule

`default_nettype wire

// ===== design/p24p_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the gain ramp step.
// Depends on p24p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module p24p_divider #(
    parameter int DVD_W = 40,
    parameter int DSR_W = 13
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DVD_W-1:0]   i_dividend,
    input  wire logic [DSR_W-1:0]   i_divisor,
    output p24p_pkg::t_div_stat     o_stat,
    output logic [DVD_W-1:0]        o_quotient
);
    import p24p_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [DSR_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DSR_W-1:0] r_dsr;
    logic [DSR_W:0]   trial;
    logic             fits;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        fits  = trial >= {1'b0, r_dsr};
        n_rem = fits ? DSR_W'(trial - {1'b0, r_dsr}) : DSR_W'(trial);
        n_quo = {r_quo[DVD_W-2:0], fits};
        n_cnt = r_cnt - CNT_W'(1);
        n_done = (r_cnt == CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(DVD_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

// ===== design/p24p_ramp.sv =====
// Configuration registers, cue gain ramp accumulator and block position.
// Depends on p24p_pkg and p24p_divider.
`timescale 1ns / 1ps
`default_nettype none

module p24p_ramp #(
    parameter int MAX_FRAMES = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [p24p_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [p24p_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                              i_accept,
    output p24p_pkg::t_frame_ctl                   o_ctl
);
    import p24p_pkg::*;

    localparam int FE_W  = $clog2(MAX_FRAMES + 1);
    localparam int POS_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [GAIN_W-1:0] r_start, r_end;
    logic [FC_W-1:0]   r_frames;
    t_conv_mode        r_mode;
    logic              r_kick;
    logic              r_neg;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic signed [INC_W-1:0] r_inc;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic [FE_W-1:0]   frames_eff;
    logic              last;
    logic              neg;
    logic [GAIN_W-1:0] diff;
    logic signed [ACC_W+1:0] sum;
    t_div_stat         div_stat;
    logic [ACC_W-1:0]  quotient;

    always_comb begin
        if (r_frames == '0) begin
            frames_eff = FE_W'(1);
        end else if (32'(r_frames) > MAX_FRAMES) begin
            frames_eff = FE_W'(MAX_FRAMES);
        end else begin
            frames_eff = FE_W'(r_frames);
        end
        neg  = r_end < r_start;
        diff = neg ? r_start - r_end : r_end - r_start;
        last = (32'(r_pos) + 32'd1) >= 32'(frames_eff);
        sum  = $signed({2'b00, r_acc}) + (ACC_W+2)'(r_inc);
        if (sum < 0) begin
            n_acc = '0;
        end else if (sum > $signed({2'b00, {ACC_W{1'b1}}})) begin
            n_acc = '1;
        end else begin
            n_acc = ACC_W'(sum);
        end
        n_pos = POS_W'(32'(r_pos) + 32'd1);
    end

    p24p_divider #(
        .DVD_W (ACC_W),
        .DSR_W (FE_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_kick),
        .i_dividend ({diff, ACC_EXTRA'(0)}),
        .i_divisor  (frames_eff),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= RST_GAIN;
            r_end    <= RST_GAIN;
            r_frames <= RST_FRAMES;
            r_mode   <= MODE_CLAMP_SCALE;
            r_kick   <= 1'b0;
        end else begin
            r_kick <= 1'b0;
            if (i_cfg_wr_en) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_GAIN_START: begin
                        r_start <= i_cfg_wdata;
                        r_kick  <= 1'b1;
                    end
                    CFG_GAIN_END: begin
                        r_end  <= i_cfg_wdata;
                        r_kick <= 1'b1;
                    end
                    CFG_FRAMES: begin
                        r_frames <= i_cfg_wdata[FC_W-1:0];
                        r_kick   <= 1'b1;
                    end
                    CFG_MODE: begin
                        r_mode <= t_conv_mode'(i_cfg_wdata[0]);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc <= '0;
            r_neg <= 1'b0;
        end else begin
            if (r_kick) begin
                r_neg <= neg;
            end
            if (div_stat.done) begin
                r_inc <= r_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= {RST_GAIN, ACC_EXTRA'(0)};
            r_pos <= '0;
        end else if (i_accept) begin
            if (last) begin
                r_acc <= {r_start, ACC_EXTRA'(0)};
                r_pos <= '0;
            end else begin
                r_acc <= n_acc;
                r_pos <= n_pos;
            end
        end
    end

    assign o_ctl.busy = r_kick | div_stat.busy | div_stat.done;
    assign o_ctl.last = last;
    assign o_ctl.mode = r_mode;
    assign o_ctl.gain = r_acc[ACC_W-1:ACC_EXTRA];

endmodule

`default_nettype wire

// ===== design/p24p_lane.sv =====
// One sample lane: gain multiply stage, then floor shift and PCM conversion stage.
// Depends on p24p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module p24p_lane (
    input  wire logic                             i_clk,
    input  wire logic                             i_load,
    input  wire logic                             i_adv,
    input  wire logic [p24p_pkg::SAMPLE_W-1:0]    i_sample,
    input  wire logic [p24p_pkg::GAIN_W-1:0]      i_gain,
    input  wire p24p_pkg::t_conv_mode             i_mode,
    output logic [p24p_pkg::PCM_W-1:0]            o_pcm
);
    import p24p_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] scaled;
    logic [PCM_W-1:0]         r_pcm;

    assign scaled = r_prod >>> GAIN_FRAC;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= $signed(i_sample) * $signed({1'b0, i_gain});
        end
        if (i_adv) begin
            r_pcm <= to_pcm24(CONV_W'(scaled), i_mode);
        end
    end

    assign o_pcm = r_pcm;

endmodule

`default_nettype wire

// ===== design/p24p_checker.sv =====
// Port-level checker for the PCM TDM output packer, bound to the top level.
// Depends on p24p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module p24p_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    input  wire logic [4*p24p_pkg::SAMPLE_W-1:0]  s_axis_tdata,
    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic [6*p24p_pkg::PCM_W-1:0]     m_axis_tdata,
    input  wire logic                             m_axis_tlast,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [p24p_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [p24p_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import p24p_pkg::*;

    logic unused;
    assign unused = s_axis_tvalid ^ (^s_axis_tdata) ^ (^i_cfg_wdata);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output item valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    a_slot_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5*PCM_W +: PCM_W] == m_axis_tdata[PCM_W +: PCM_W])
                       && (m_axis_tdata[4*PCM_W +: PCM_W] == m_axis_tdata[0 +: PCM_W]))
        else $error("repeated main slots differ");

    a_ramp_recalc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en && (i_cfg_index != CFG_MODE) |=> !s_axis_tready)
        else $error("input accepted while ramp step is being recomputed");

endmodule

bind pcm24_tdm_output_packer p24p_checker u_p24p_checker (.*);

`default_nettype wire
